// File: rtl/core/tct_pkg.sv
// Shared types and constants for the two-list cell tracker.
`timescale 1ns / 1ps
package tct_pkg;

    localparam logic [6:0] NONE_LINK   = 7'd127;
    localparam logic [1:0] PIECE_EMPTY = 2'd2;

    localparam logic [1:0] REQ_TAKE    = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_WALK    = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_WRONG = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_UNLINK,
        S_APPEND,
        S_LINK,
        S_WEMIT
    } tct_state_t;

    typedef enum logic [2:0] {
        EM_RANGE,
        EM_WRONG,
        EM_EMPTY,
        EM_DONE,
        EM_MEMBER
    } tct_emit_t;

    typedef enum logic [1:0] {
        RD_POS,
        RD_HEAD,
        RD_NEXT
    } tct_rd_src_t;

    typedef struct packed {
        logic        load;
        logic        rd;
        tct_rd_src_t rd_src;
        logic        walk_start;
        logic        walk_adv;
        logic        unlink;
        logic        append;
        logic        link;
        logic        emit;
        tct_emit_t   emit_kind;
    } tct_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       pos_bad;
        logic       head_bad;
        logic       wrong;
        logic       last;
        logic       slot_free;
    } tct_stat_t;

endpackage

// File: rtl/core/two_list_cell_tracker_top.sv
// Top level of the two-list cell tracker.
//
//  channel | ports               | carries
//  s_      | s_valid / s_ready   | one request item: take, release or walk
//  m_      | m_valid / m_ready   | one result item per take/release, one per walked cell
//
//  Take or release: from accept to result the steps are check and read, unlink, append and link.
//  Walk: the list head is read first, then one member per cycle from the link memory unless m_ready stalls.
//  Next request is accepted the cycle after the last result is loaded to the output register.
//  Reset (synchronous, aresetn low): lists in index order, all cells empty, no clearing pass.
//  A stalled m_ready holds the sequencer in any step that emits a result.
`timescale 1ns / 1ps
module two_list_cell_tracker_top #(
    parameter int CELLS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [5:0] s_cell_pos,
    input  logic       s_player_id,
    input  logic       s_piece_kind,
    input  logic       s_list_sel,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_out_pos,
    output logic       m_out_player,
    output logic [1:0] m_out_piece,
    output logic [1:0] m_status,
    output logic       m_last_flag,
    output logic [6:0] m_empty_count,
    output logic [6:0] m_taken_count
);
    import tct_pkg::*;

    tct_cmd_t  cmd;
    tct_stat_t stat;

    tct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tct_dp #(
        .CELLS (CELLS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_req_type    (s_req_type),
        .s_cell_pos    (s_cell_pos),
        .s_player_id   (s_player_id),
        .s_piece_kind  (s_piece_kind),
        .s_list_sel    (s_list_sel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_pos     (m_out_pos),
        .m_out_player  (m_out_player),
        .m_out_piece   (m_out_piece),
        .m_status      (m_status),
        .m_last_flag   (m_last_flag),
        .m_empty_count (m_empty_count),
        .m_taken_count (m_taken_count)
    );

endmodule

// File: rtl/core/tct_ctrl.sv
// Sequencer for take, release and walk requests.
`timescale 1ns / 1ps
module tct_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tct_pkg::tct_stat_t stat,
    output tct_pkg::tct_cmd_t  cmd
);
    import tct_pkg::*;

    tct_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                case (stat.req)
                    REQ_TAKE, REQ_RELEASE: begin
                        if (stat.pos_bad) begin
                            if (stat.slot_free) begin
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = EM_RANGE;
                                state_next    = S_IDLE;
                            end
                        end else begin
                            cmd.rd     = 1'b1;
                            cmd.rd_src = RD_POS;
                            state_next = S_UNLINK;
                        end
                    end
                    REQ_WALK: begin
                        if (stat.head_bad) begin
                            if (stat.slot_free) begin
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = EM_EMPTY;
                                state_next    = S_IDLE;
                            end
                        end else begin
                            cmd.rd         = 1'b1;
                            cmd.rd_src     = RD_HEAD;
                            cmd.walk_start = 1'b1;
                            state_next     = S_WEMIT;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_UNLINK: begin
                if (stat.wrong) begin
                    if (stat.slot_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = EM_WRONG;
                        state_next    = S_IDLE;
                    end
                end else begin
                    cmd.unlink = 1'b1;
                    state_next = S_APPEND;
                end
            end
            S_APPEND: begin
                cmd.append = 1'b1;
                state_next = S_LINK;
            end
            S_LINK: begin
                if (stat.slot_free) begin
                    cmd.link      = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EM_DONE;
                    state_next    = S_IDLE;
                end
            end
            S_WEMIT: begin
                if (stat.slot_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EM_MEMBER;
                    if (stat.last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.walk_adv = 1'b1;
                        cmd.rd       = 1'b1;
                        cmd.rd_src   = RD_NEXT;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/tct_dp.sv
// Link memories, list heads and tails, counts and result register.
`timescale 1ns / 1ps
module tct_dp #(
    parameter int CELLS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tct_pkg::tct_cmd_t  cmd,
    output tct_pkg::tct_stat_t stat,
    input  logic [1:0]        s_req_type,
    input  logic [5:0]        s_cell_pos,
    input  logic              s_player_id,
    input  logic              s_piece_kind,
    input  logic              s_list_sel,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [5:0]        m_out_pos,
    output logic              m_out_player,
    output logic [1:0]        m_out_piece,
    output logic [1:0]        m_status,
    output logic              m_last_flag,
    output logic [6:0]        m_empty_count,
    output logic [6:0]        m_taken_count
);
    import tct_pkg::*;

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [6:0] NCELL = 7'(CELLS);
    localparam logic [7:0] NCELL8 = 8'(CELLS);

    logic [6:0] next_mem [CELLS];
    logic [6:0] prev_mem [CELLS];
    logic [2:0] info_mem [CELLS];
    logic [CELLS-1:0] nv_reg, pv_reg, iv_reg, in_taken_reg;

    logic [1:0] req_reg;
    logic [5:0] pos_reg;
    logic       pl_reg, pk_reg, sel_reg;
    logic [6:0] eh_reg, et_reg, th_reg, tt_reg, ec_reg, tc_reg;
    logic [6:0] n_reg;
    logic [6:0] tgt_reg;
    logic       tgt_ok_reg;

    logic [6:0] ra_reg;
    logic [6:0] nx_q_reg, pv_q_reg;
    logic [2:0] info_q_reg;
    logic       nv_q_reg, pvv_q_reg, iv_q_reg;

    logic [6:0] nx, pv, def_nx, def_pv, rd_addr, sel_head;
    logic       rd_player;
    logic [1:0] rd_piece;
    logic       is_take;
    logic [6:0] dst_head, dst_tail;
    logic       nx_ok, pv_ok, dst_ok;

    logic       nw_we, pw_we, iw_we;
    logic [6:0] nw_a, pw_a, nw_d, pw_d;
    logic [2:0] iw_d;

    always_comb begin
        def_nx = ({1'b0, ra_reg} + 8'd1 < NCELL8) ? ra_reg + 7'd1 : NONE_LINK;
        def_pv = (ra_reg != 7'd0) ? ra_reg - 7'd1 : NONE_LINK;
        nx        = nv_q_reg  ? nx_q_reg : def_nx;
        pv        = pvv_q_reg ? pv_q_reg : def_pv;
        rd_player = iv_q_reg ? info_q_reg[2] : 1'b0;
        rd_piece  = iv_q_reg ? info_q_reg[1:0] : PIECE_EMPTY;
        nx_ok     = nx < NCELL;
        pv_ok     = pv < NCELL;
        is_take   = req_reg == REQ_TAKE;
        sel_head  = sel_reg ? th_reg : eh_reg;
        dst_head  = is_take ? th_reg : eh_reg;
        dst_tail  = is_take ? tt_reg : et_reg;
        dst_ok    = (dst_head < NCELL) && (dst_tail < NCELL);
    end

    always_comb begin
        case (cmd.rd_src)
            RD_POS:  rd_addr = {1'b0, pos_reg};
            RD_HEAD: rd_addr = sel_head;
            RD_NEXT: rd_addr = nx;
            default: rd_addr = {1'b0, pos_reg};
        endcase
    end

    assign stat.req       = req_reg;
    assign stat.pos_bad   = !({1'b0, pos_reg} < NCELL);
    assign stat.head_bad  = !(sel_head < NCELL);
    assign stat.wrong     = is_take == in_taken_reg[pos_reg[AW-1:0]];
    assign stat.last      = !nx_ok || (n_reg == NCELL - 7'd1);
    assign stat.slot_free = !m_valid || m_ready;

    always_comb begin
        nw_we = 1'b0;
        nw_a  = {1'b0, pos_reg};
        nw_d  = NONE_LINK;
        pw_we = 1'b0;
        pw_a  = {1'b0, pos_reg};
        pw_d  = NONE_LINK;
        iw_we = cmd.append;
        iw_d  = is_take ? {pl_reg, 1'b0, pk_reg} : {rd_player, PIECE_EMPTY};
        if (cmd.unlink) begin
            nw_we = pv_ok;
            nw_a  = pv;
            nw_d  = nx;
            pw_we = nx_ok;
            pw_a  = nx;
            pw_d  = pv;
        end else if (cmd.append) begin
            nw_we = 1'b1;
            pw_we = 1'b1;
            pw_d  = dst_ok ? dst_tail : NONE_LINK;
        end else if (cmd.link) begin
            nw_we = tgt_ok_reg;
            nw_a  = tgt_reg;
            nw_d  = {1'b0, pos_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (nw_we) begin
            next_mem[nw_a[AW-1:0]] <= nw_d;
        end
        if (pw_we) begin
            prev_mem[pw_a[AW-1:0]] <= pw_d;
        end
        if (iw_we) begin
            info_mem[pos_reg[AW-1:0]] <= iw_d;
        end
        if (cmd.rd) begin
            ra_reg     <= rd_addr;
            nx_q_reg   <= next_mem[rd_addr[AW-1:0]];
            pv_q_reg   <= prev_mem[rd_addr[AW-1:0]];
            info_q_reg <= info_mem[rd_addr[AW-1:0]];
            nv_q_reg   <= nv_reg[rd_addr[AW-1:0]];
            pvv_q_reg  <= pv_reg[rd_addr[AW-1:0]];
            iv_q_reg   <= iv_reg[rd_addr[AW-1:0]];
        end
        if (cmd.load) begin
            req_reg <= s_req_type;
            pos_reg <= s_cell_pos;
            pl_reg  <= s_player_id;
            pk_reg  <= s_piece_kind;
            sel_reg <= s_list_sel;
        end
        if (cmd.append) begin
            tgt_reg    <= dst_tail;
            tgt_ok_reg <= dst_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg       <= '0;
            pv_reg       <= '0;
            iv_reg       <= '0;
            in_taken_reg <= '0;
            eh_reg       <= 7'd0;
            et_reg       <= NCELL - 7'd1;
            th_reg       <= NONE_LINK;
            tt_reg       <= NONE_LINK;
            ec_reg       <= NCELL;
            tc_reg       <= 7'd0;
            n_reg        <= 7'd0;
        end else begin
            if (nw_we) begin
                nv_reg[nw_a[AW-1:0]] <= 1'b1;
            end
            if (pw_we) begin
                pv_reg[pw_a[AW-1:0]] <= 1'b1;
            end
            if (iw_we) begin
                iv_reg[pos_reg[AW-1:0]]       <= 1'b1;
                in_taken_reg[pos_reg[AW-1:0]] <= is_take;
            end
            if (cmd.walk_start) begin
                n_reg <= 7'd0;
            end else if (cmd.walk_adv) begin
                n_reg <= n_reg + 7'd1;
            end
            if (cmd.unlink) begin
                if (is_take) begin
                    if (!pv_ok) eh_reg <= nx;
                    if (!nx_ok) et_reg <= pv;
                end else begin
                    if (!pv_ok) th_reg <= nx;
                    if (!nx_ok) tt_reg <= pv;
                end
            end
            if (cmd.append) begin
                if (is_take) begin
                    if (!dst_ok) th_reg <= {1'b0, pos_reg};
                    tt_reg <= {1'b0, pos_reg};
                    ec_reg <= ec_reg - 7'd1;
                    tc_reg <= tc_reg + 7'd1;
                end else begin
                    if (!dst_ok) eh_reg <= {1'b0, pos_reg};
                    et_reg <= {1'b0, pos_reg};
                    ec_reg <= ec_reg + 7'd1;
                    tc_reg <= tc_reg - 7'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.emit) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_empty_count <= ec_reg;
            m_taken_count <= tc_reg;
            case (cmd.emit_kind)
                EM_RANGE: begin
                    m_out_pos    <= pos_reg;
                    m_out_player <= 1'b0;
                    m_out_piece  <= PIECE_EMPTY;
                    m_status     <= STAT_WRONG;
                    m_last_flag  <= 1'b1;
                end
                EM_WRONG: begin
                    m_out_pos    <= pos_reg;
                    m_out_player <= rd_player;
                    m_out_piece  <= rd_piece;
                    m_status     <= STAT_WRONG;
                    m_last_flag  <= 1'b1;
                end
                EM_EMPTY: begin
                    m_out_pos    <= 6'd0;
                    m_out_player <= 1'b0;
                    m_out_piece  <= PIECE_EMPTY;
                    m_status     <= STAT_EMPTY;
                    m_last_flag  <= 1'b1;
                end
                EM_DONE: begin
                    m_out_pos    <= pos_reg;
                    m_out_player <= is_take ? pl_reg : rd_player;
                    m_out_piece  <= is_take ? {1'b0, pk_reg} : PIECE_EMPTY;
                    m_status     <= STAT_OK;
                    m_last_flag  <= 1'b1;
                end
                EM_MEMBER: begin
                    m_out_pos    <= ra_reg[5:0];
                    m_out_player <= rd_player;
                    m_out_piece  <= sel_reg ? rd_piece : {1'b0, pk_reg};
                    m_status     <= STAT_OK;
                    m_last_flag  <= stat.last;
                end
                default: begin
                    m_out_pos    <= pos_reg;
                    m_out_player <= 1'b0;
                    m_out_piece  <= PIECE_EMPTY;
                    m_status     <= STAT_WRONG;
                    m_last_flag  <= 1'b1;
                end
            endcase
        end
    end

endmodule

// File: sim/two_list_cell_tracker_top_tb.sv
// Testbench for the two-list cell tracker: random and directed requests against a predictor.
`timescale 1ns / 1ps
module two_list_cell_tracker_top_tb;
    import tct_pkg::*;

    localparam int CELLS = 64;

    typedef struct packed {
        logic [5:0] pos;
        logic       player;
        logic [1:0] piece;
        logic [1:0] status;
        logic       last;
        logic [6:0] empty_cnt;
        logic [6:0] taken_cnt;
    } cell_result_t;

    class cell_list_scoreboard;
        logic [6:0]   nxt[CELLS];
        logic [6:0]   prv[CELLS];
        logic         plr[CELLS];
        logic [1:0]   pce[CELLS];
        logic         taken[CELLS];
        logic [6:0]   e_head, e_tail, t_head, t_tail;
        logic [6:0]   e_total, t_total;
        cell_result_t pending_results[$];
        int           mismatches;

        function void reset_lists();
            for (int i = 0; i < CELLS; i++) begin
                nxt[i] = (i + 1 < CELLS) ? 7'(i + 1) : NONE_LINK;
                prv[i] = (i > 0) ? 7'(i - 1) : NONE_LINK;
                plr[i] = 1'b0;
                pce[i] = PIECE_EMPTY;
                taken[i] = 1'b0;
            end
            e_head = 7'd0;
            e_tail = 7'(CELLS - 1);
            t_head = NONE_LINK;
            t_tail = NONE_LINK;
            e_total = 7'(CELLS);
            t_total = 7'd0;
            mismatches = 0;
        endfunction

        function bit is_cell(logic [6:0] c);
            return c < CELLS;
        endfunction

        function void push_result(logic [5:0] p, logic pl, logic [1:0] pc,
                                  logic [1:0] st, logic lst);
            cell_result_t r;
            r = '{p, pl, pc, st, lst, e_total, t_total};
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void unlink_cell(int p, bit from_taken);
            logic [6:0] pv;
            logic [6:0] nx;
            pv = prv[p];
            nx = nxt[p];
            if (is_cell(pv)) nxt[pv] = nx;
            else if (from_taken) t_head = nx;
            else e_head = nx;
            if (is_cell(nx)) prv[nx] = pv;
            else if (from_taken) t_tail = pv;
            else e_tail = pv;
        endfunction

        function void append_cell(int p, bit to_taken);
            logic [6:0] hd;
            logic [6:0] tl;
            hd = to_taken ? t_head : e_head;
            tl = to_taken ? t_tail : e_tail;
            nxt[p] = NONE_LINK;
            if (is_cell(hd) && is_cell(tl)) begin
                nxt[tl] = 7'(p);
                prv[p] = tl;
            end else begin
                hd = 7'(p);
                prv[p] = NONE_LINK;
            end
            tl = 7'(p);
            if (to_taken) begin
                t_head = hd;
                t_tail = tl;
            end else begin
                e_head = hd;
                e_tail = tl;
            end
        endfunction

        function void note_request(logic [1:0] req, logic [5:0] pos, logic pl,
                                   logic pk, logic sel);
            logic [6:0] cur;
            logic [6:0] nx;
            int         n;
            if (req == REQ_TAKE || req == REQ_RELEASE) begin
                if (pos >= CELLS) begin
                    push_result(pos, 1'b0, PIECE_EMPTY, STAT_WRONG, 1'b1);
                end else if ((req == REQ_TAKE) == taken[pos]) begin
                    push_result(pos, plr[pos], pce[pos], STAT_WRONG, 1'b1);
                end else begin
                    if (req == REQ_TAKE) begin
                        unlink_cell(pos, 0);
                        append_cell(pos, 1);
                        taken[pos] = 1'b1;
                        e_total--;
                        t_total++;
                        plr[pos] = pl;
                        pce[pos] = {1'b0, pk};
                    end else begin
                        unlink_cell(pos, 1);
                        append_cell(pos, 0);
                        taken[pos] = 1'b0;
                        e_total++;
                        t_total--;
                        pce[pos] = PIECE_EMPTY;
                    end
                    push_result(pos, plr[pos], pce[pos], STAT_OK, 1'b1);
                end
            end else if (req == REQ_WALK) begin
                cur = sel ? t_head : e_head;
                n = 0;
                if (!is_cell(cur)) begin
                    push_result(6'd0, 1'b0, PIECE_EMPTY, STAT_EMPTY, 1'b1);
                end else begin
                    while (is_cell(cur) && n < CELLS) begin
                        nx = nxt[cur];
                        push_result(cur[5:0], plr[cur], sel ? pce[cur] : {1'b0, pk},
                                    STAT_OK, !is_cell(nx) || n + 1 >= CELLS);
                        n++;
                        cur = nx;
                    end
                end
            end
        endfunction

        function void check_result(cell_result_t got);
            cell_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_req_type;
    logic [5:0] s_cell_pos;
    logic       s_player_id;
    logic       s_piece_kind;
    logic       s_list_sel;
    logic       m_valid;
    logic       m_ready;
    logic [5:0] m_out_pos;
    logic       m_out_player;
    logic [1:0] m_out_piece;
    logic [1:0] m_status;
    logic       m_last_flag;
    logic [6:0] m_empty_count;
    logic [6:0] m_taken_count;

    cell_list_scoreboard tracker_sb;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    two_list_cell_tracker_top #(.CELLS(CELLS)) u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_request(logic [1:0] req, logic [5:0] pos, logic pl,
                                logic pk, logic sel);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_cell_pos   <= pos;
        s_player_id  <= pl;
        s_piece_kind <= pk;
        s_list_sel   <= sel;
        do @(posedge aclk); while (!s_ready);
        tracker_sb.note_request(req, pos, pl, pk, sel);
        @(negedge aclk);
    endtask

    task automatic send_random(int count);
        logic [5:0] pos;
        int         kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            pos = (kind < 5) ? 6'($urandom) : 6'($urandom_range(15));
            if (kind < 45)
                send_request(REQ_TAKE, pos, 1'($urandom), 1'($urandom), 1'($urandom));
            else if (kind < 80)
                send_request(REQ_RELEASE, pos, 1'($urandom), 1'($urandom), 1'($urandom));
            else if (kind < 97)
                send_request(REQ_WALK, pos, 1'($urandom), 1'($urandom), 1'($urandom));
            else
                send_request(2'd3, pos, 1'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker_sb.check_result({m_out_pos, m_out_player, m_out_piece, m_status,
                                     m_last_flag, m_empty_count, m_taken_count});
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        tracker_sb = new();
        tracker_sb.reset_lists();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req_type   = REQ_TAKE;
        s_cell_pos   = 6'd0;
        s_player_id  = 1'b0;
        s_piece_kind = 1'b0;
        s_list_sel   = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 69;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_request(REQ_WALK, 6'd0, 1'b0, 1'b1, 1'b1);
        send_request(REQ_WALK, 6'd0, 1'b1, 1'b1, 1'b0);
        send_request(REQ_RELEASE, 6'd5, 1'b0, 1'b0, 1'b0);
        send_request(REQ_TAKE, 6'd0, 1'b1, 1'b1, 1'b0);
        send_request(REQ_TAKE, 6'd63, 1'b0, 1'b0, 1'b1);
        send_request(REQ_TAKE, 6'd31, 1'b1, 1'b0, 1'b0);
        send_request(REQ_TAKE, 6'd0, 1'b0, 1'b0, 1'b0);
        send_request(REQ_WALK, 6'd0, 1'b0, 1'b0, 1'b1);
        send_request(REQ_WALK, 6'd63, 1'b0, 1'b0, 1'b0);
        send_request(REQ_RELEASE, 6'd31, 1'b0, 1'b1, 1'b1);
        send_request(REQ_RELEASE, 6'd0, 1'b1, 1'b0, 1'b0);
        send_request(REQ_RELEASE, 6'd63, 1'b0, 1'b0, 1'b0);
        send_request(2'd3, 6'd63, 1'b1, 1'b1, 1'b1);
        for (int i = 0; i < CELLS; i++)
            send_request(REQ_TAKE, 6'(i), i[0], i[1], 1'b0);
        send_request(REQ_WALK, 6'd0, 1'b0, 1'b0, 1'b0);
        send_request(REQ_WALK, 6'd0, 1'b0, 1'b0, 1'b1);
        for (int i = CELLS - 1; i >= 0; i -= 2)
            send_request(REQ_RELEASE, 6'(i), 1'b0, 1'b0, 1'b0);

        send_random(23);
        send_idle_pct = 69;
        recv_idle_pct = 27;
        send_random(23);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(23);
        s_valid <= 1'b0;

        while (tracker_sb.pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (tracker_sb.mismatches == 0 && tracker_sb.pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: files.f
rtl/core/tct_pkg.sv
rtl/core/tct_ctrl.sv
rtl/core/tct_dp.sv
rtl/core/two_list_cell_tracker_top.sv
sim/two_list_cell_tracker_top_tb.sv
